// ===== src/four_class_priority_worklist_assert.svh =====
// Assertion macros used by the checker file.
`ifndef FOUR_CLASS_PRIORITY_WORKLIST_ASSERT_SVH
`define FOUR_CLASS_PRIORITY_WORKLIST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define FCPW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define FCPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fcpw_pkg.sv =====
`default_nettype none
package fcpw_pkg;

  // id space seen on the ports
  localparam int ID_W = 8;
  localparam int ID_SPACE = 2 ** ID_W;
  localparam int DEFAULT_NODE_COUNT = 256;
  localparam int LIST_COUNT = 4;

  // operation codes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_ERASE = 2'd1;
  localparam logic [1:0] OP_POP   = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  // predicate kinds
  localparam logic [1:0] KIND_CONST = 2'd0;
  localparam logic [1:0] KIND_EQ    = 2'd1;

  // lists, highest priority first
  localparam logic [1:0] LIST_NEG_EQ  = 2'd0;
  localparam logic [1:0] LIST_POS     = 2'd1;
  localparam logic [1:0] LIST_NEG_ABN = 2'd2;
  localparam logic [1:0] LIST_REST    = 2'd3;

  typedef struct packed {
    logic [1:0]      operation;
    logic [ID_W-1:0] node_id;
    logic [1:0]      predicate_kind;
    logic            negated;
    logic            is_normal;
    logic            is_leaf;
  } req_item_t;

  typedef struct packed {
    logic [ID_W-1:0] result_node;
    logic            result_valid;
    logic            in_list;
    logic            all_empty;
    logic            error_flag;
  } rsp_item_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PUSH_A = 5'b00010,
    ST_PUSH_B = 5'b00100,
    ST_UNLINK = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

endpackage
`default_nettype wire

// ===== src/four_class_priority_worklist.sv =====
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_stall  | fcpw_pkg::req_item_t
// rsp     | out       | rsp_valid / rsp_stall  | fcpw_pkg::rsp_item_t
//
// Push of a new node: PUSH_A, PUSH_B, DONE; erase or pop of a listed
// node: UNLINK, DONE; all else: DONE. Link RAMs (one write port each) set this.
// One item is in work at a time; req_stall is high until its result is
// loaded into the output register, which may wait there under rsp_stall.
// Reset (rst, synchronous) empties all four lists at once: membership bits
// and list ends are flip-flops, link RAM contents need no clearing.
`default_nettype none
module four_class_priority_worklist #(
  parameter int NODE_COUNT = fcpw_pkg::DEFAULT_NODE_COUNT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire fcpw_pkg::req_item_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output fcpw_pkg::rsp_item_t      rsp
);

  // only ids below the port's id space can ever be listed
  localparam int DEPTH = (NODE_COUNT < fcpw_pkg::ID_SPACE) ? NODE_COUNT : fcpw_pkg::ID_SPACE;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int LINK_W = IDX_W + 1;
  localparam logic [LINK_W-1:0] LINK_NULL = {1'b1, {IDX_W{1'b0}}};
  localparam logic [31:0] NODE_LIMIT = 32'(NODE_COUNT);

  fcpw_pkg::state_t state, state_next;

  logic [DEPTH-1:0]  listed;
  logic [LINK_W-1:0] head [fcpw_pkg::LIST_COUNT];
  logic [LINK_W-1:0] tail [fcpw_pkg::LIST_COUNT];

  // per-item latches
  logic [IDX_W-1:0] tgt;
  logic [1:0]       lst;
  logic             at_tail;
  logic             listed_s;
  logic             err_s;
  logic             is_pop;
  logic             pop_hit;

  // link RAM ports
  logic              nx_we, pv_we;
  logic [IDX_W-1:0]  nx_waddr, pv_waddr, rd_idx;
  logic [LINK_W-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

  logic              accept, in_range, listed_now, out_load;
  logic              top_valid;
  logic [IDX_W-1:0]  top_idx;
  logic [1:0]        push_lst;
  logic [LINK_W-1:0] tgt_link, end_link;

  assign req_stall = (state != fcpw_pkg::ST_IDLE);
  assign accept = req_valid && !req_stall;
  assign in_range = ({{(32 - fcpw_pkg::ID_W){1'b0}}, req.node_id} < NODE_LIMIT);
  assign listed_now = in_range && listed[req.node_id[IDX_W-1:0]];
  assign tgt_link = {1'b0, tgt};
  assign end_link = at_tail ? tail[lst] : head[lst];
  assign out_load = (state == fcpw_pkg::ST_DONE) && (!rsp_valid || !rsp_stall);

  // head of the highest non-empty list
  always_comb begin
    top_valid = 1'b0;
    top_idx = '0;
    for (int k = fcpw_pkg::LIST_COUNT - 1; k >= 0; k--) begin
      if (!head[k][IDX_W]) begin
        top_valid = 1'b1;
        top_idx = head[k][IDX_W-1:0];
      end
    end
  end

  // list choice for a push
  always_comb begin
    if (!req.negated) begin
      push_lst = fcpw_pkg::LIST_POS;
    end else if (!req.is_normal) begin
      push_lst = fcpw_pkg::LIST_NEG_ABN;
    end else if (req.predicate_kind == fcpw_pkg::KIND_EQ) begin
      push_lst = fcpw_pkg::LIST_NEG_EQ;
    end else begin
      push_lst = fcpw_pkg::LIST_REST;
    end
  end

  // links of the unlink target are read as the item is taken
  assign rd_idx = (req.operation == fcpw_pkg::OP_POP) ? top_idx : req.node_id[IDX_W-1:0];

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      fcpw_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.operation)
            fcpw_pkg::OP_PUSH: begin
              if (!listed_now && in_range && req.predicate_kind != fcpw_pkg::KIND_CONST) begin
                state_next = fcpw_pkg::ST_PUSH_A;
              end else begin
                state_next = fcpw_pkg::ST_DONE;
              end
            end
            fcpw_pkg::OP_ERASE: begin
              state_next = listed_now ? fcpw_pkg::ST_UNLINK : fcpw_pkg::ST_DONE;
            end
            fcpw_pkg::OP_POP: begin
              state_next = top_valid ? fcpw_pkg::ST_UNLINK : fcpw_pkg::ST_DONE;
            end
            default: begin
              state_next = fcpw_pkg::ST_DONE;
            end
          endcase
        end
      end
      fcpw_pkg::ST_PUSH_A: state_next = fcpw_pkg::ST_PUSH_B;
      fcpw_pkg::ST_PUSH_B: state_next = fcpw_pkg::ST_DONE;
      fcpw_pkg::ST_UNLINK: state_next = fcpw_pkg::ST_DONE;
      fcpw_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = fcpw_pkg::ST_IDLE;
        end
      end
      default: state_next = fcpw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcpw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item latches
  always_ff @(posedge clk) begin
    if (accept) begin
      tgt      <= rd_idx;
      lst      <= push_lst;
      at_tail  <= (push_lst == fcpw_pkg::LIST_REST) && req.is_leaf;
      listed_s <= listed_now;
      err_s    <= (req.operation == fcpw_pkg::OP_PUSH) && listed_now;
      is_pop   <= (req.operation == fcpw_pkg::OP_POP);
      pop_hit  <= top_valid;
    end
  end

  // link RAM writes; a tail push mirrors a head push with next/prev swapped
  always_comb begin
    nx_we = 1'b0;
    pv_we = 1'b0;
    nx_waddr = tgt;
    pv_waddr = tgt;
    nx_wdata = LINK_NULL;
    pv_wdata = LINK_NULL;
    case (state)
      fcpw_pkg::ST_PUSH_A: begin
        if (at_tail) begin
          pv_we = 1'b1;
          pv_wdata = end_link;
          nx_we = !end_link[IDX_W];
          nx_waddr = end_link[IDX_W-1:0];
          nx_wdata = tgt_link;
        end else begin
          nx_we = 1'b1;
          nx_wdata = end_link;
          pv_we = !end_link[IDX_W];
          pv_waddr = end_link[IDX_W-1:0];
          pv_wdata = tgt_link;
        end
      end
      fcpw_pkg::ST_PUSH_B: begin
        nx_we = at_tail;
        pv_we = !at_tail;
      end
      fcpw_pkg::ST_UNLINK: begin
        nx_we = !pv_rdata[IDX_W];
        nx_waddr = pv_rdata[IDX_W-1:0];
        nx_wdata = nx_rdata;
        pv_we = !nx_rdata[IDX_W];
        pv_waddr = nx_rdata[IDX_W-1:0];
        pv_wdata = pv_rdata;
      end
      default: begin
      end
    endcase
  end

  fcpw_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH)) u_next_ram (
    .clk  (clk),
    .we   (nx_we),
    .waddr(nx_waddr),
    .wdata(nx_wdata),
    .raddr(rd_idx),
    .rdata(nx_rdata)
  );

  fcpw_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH)) u_prev_ram (
    .clk  (clk),
    .we   (pv_we),
    .waddr(pv_waddr),
    .wdata(pv_wdata),
    .raddr(rd_idx),
    .rdata(pv_rdata)
  );

  // list ends and membership bits
  always_ff @(posedge clk) begin
    if (rst) begin
      listed <= '0;
      for (int k = 0; k < fcpw_pkg::LIST_COUNT; k++) begin
        head[k] <= LINK_NULL;
        tail[k] <= LINK_NULL;
      end
    end else begin
      case (state)
        fcpw_pkg::ST_PUSH_A: begin
          if (at_tail) begin
            tail[lst] <= tgt_link;
            if (end_link[IDX_W]) begin
              head[lst] <= tgt_link;
            end
          end else begin
            head[lst] <= tgt_link;
            if (end_link[IDX_W]) begin
              tail[lst] <= tgt_link;
            end
          end
        end
        fcpw_pkg::ST_PUSH_B: begin
          listed[tgt] <= 1'b1;
        end
        fcpw_pkg::ST_UNLINK: begin
          listed[tgt] <= 1'b0;
          for (int k = 0; k < fcpw_pkg::LIST_COUNT; k++) begin
            if (pv_rdata[IDX_W] && head[k] == tgt_link) begin
              head[k] <= nx_rdata;
            end
            if (nx_rdata[IDX_W] && tail[k] == tgt_link) begin
              tail[k] <= pv_rdata;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (is_pop) begin
        rsp.result_valid <= pop_hit;
        rsp.result_node  <= pop_hit ? fcpw_pkg::ID_W'(tgt) : '0;
      end else begin
        rsp.result_valid <= top_valid;
        rsp.result_node  <= top_valid ? fcpw_pkg::ID_W'(top_idx) : '0;
      end
      rsp.in_list    <= listed_s;
      rsp.all_empty  <= !top_valid;
      rsp.error_flag <= err_s;
    end
  end

endmodule
`default_nettype wire

// ===== src/fcpw_ram.sv =====
`default_nettype none
module fcpw_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/fcpw_checker.sv =====
`default_nettype none
`include "four_class_priority_worklist_assert.svh"
module fcpw_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_stall,
  input wire fcpw_pkg::req_item_t req,
  input wire logic                rsp_valid,
  input wire logic                rsp_stall,
  input wire fcpw_pkg::rsp_item_t rsp
);

  logic req_wait, rsp_wait, rsp_none, none_ok;

  assign req_wait = req_valid && req_stall;
  assign rsp_wait = rsp_valid && rsp_stall;
  assign rsp_none = rsp_valid && !rsp.result_valid;
  assign none_ok = rsp.all_empty && (rsp.result_node == '0);

  // an offered item held under stall stays put
  `FCPW_ASSERT_NEXT(a_req_hold, req_wait, req_valid && $stable(req), "req changed while stalled")

  // a result held under stall stays put
  `FCPW_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp), "rsp changed while stalled")

  // one item at a time: taking an item closes the input
  `FCPW_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall, "input open after an item")

  // no node reported means every list is empty
  `FCPW_ASSERT_NOW(a_empty, rsp_none, none_ok, "empty result inconsistent")

  // a rejected push always names a listed node
  `FCPW_ASSERT_NOW(a_err_listed, rsp_valid && rsp.error_flag, rsp.in_list, "error without membership")

endmodule

bind four_class_priority_worklist fcpw_checker u_fcpw_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);
`default_nettype wire
